>>> hdl/bounding_sphere_merge_assert.svh
// Assertion macros for the bounding sphere merge block.
`ifndef BOUNDING_SPHERE_MERGE_ASSERT_SVH
`define BOUNDING_SPHERE_MERGE_ASSERT_SVH
// Check that a condition implies a consequence on the same edge.
`define BSM_ASSERT_IMP(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);
// Check that a condition implies a consequence on the next edge.
`define BSM_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);
`endif

>>> hdl/bsm_pkg.sv
// Shared constants and types of the bounding sphere merge block.
package bsm_pkg;
  localparam int MaxSpheres = 64;
  localparam int AddrW = $clog2(MaxSpheres);
  localparam int CntW = $clog2(MaxSpheres + 1);
  localparam int SumW = 32 + CntW;
  localparam int EntryW = 32 * 3 + 31;
  localparam int QuotW = SumW;
  localparam int RadMax = 32'h7FFF_FFFF;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_DIFF  = 8'b0000_1000,
    S_SQ    = 8'b0001_0000,
    S_SQRT  = 8'b0010_0000,
    S_CMP   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;
endpackage

>>> hdl/bounding_sphere_merge.sv
// Bounding sphere merge: stores spheres, then finds the mean center and enclosing radius.
// Loading: one sphere per cycle, busy low while loading (the last sphere is taken the same way).
// Final pass: three restoring divisions in lockstep, then per stored sphere one read,
// one difference, squaring of the three axes, 34 square-root steps and a compare;
// the output state then forms the result; its strobe lasts one cycle, busy drops with it, no stall.
// Reset (rst, synchronous) clears sums, count and control; the sphere RAM is not cleared.
module bounding_sphere_merge (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] center_x,
  input  logic [31:0] center_y,
  input  logic [31:0] center_z,
  input  logic [30:0] sphere_radius,
  input  logic        last_sphere,
  output logic        done,
  output logic [31:0] bound_x,
  output logic [31:0] bound_y,
  output logic [31:0] bound_z,
  output logic [30:0] bound_radius,
  output logic        radius_saturated
);
  localparam int SW = bsm_pkg::SumW;
  localparam int AW = bsm_pkg::AddrW;
  localparam int CW = bsm_pkg::CntW;
  localparam int DCW = $clog2(SW + 1);

  bsm_pkg::state_t state;
  logic [CW-1:0] count, idx;
  logic signed [SW-1:0] sum_x, sum_y, sum_z;
  logic accept, store;

  // Division: three restoring dividers in lockstep on magnitudes.
  logic [SW-1:0] qx, qy, qz, rx, ry, rz;
  logic [DCW-1:0] dcnt;
  logic signed [32:0] cx, cy, cz;

  logic [bsm_pkg::EntryW-1:0] wdata, rdata;
  logic signed [33:0] dx, dy, dz;
  logic [33:0] mag;
  logic [1:0] axis;
  logic [67:0] sq, sqsum;
  logic [67:0] rad;
  logic [35:0] rem;
  logic [33:0] root;
  logic [5:0] scnt;
  logic [30:0] rsph;
  logic [34:0] best;

  assign busy = (state != bsm_pkg::S_LOAD);
  assign accept = start && !busy;
  assign store = accept && (count < CW'(bsm_pkg::MaxSpheres));
  assign wdata = {center_x, center_y, center_z, sphere_radius};

  bsm_ram #(.Width(bsm_pkg::EntryW), .Depth(bsm_pkg::MaxSpheres)) u_ram (
    .clk(clk), .we(store), .waddr(count[AW-1:0]), .wdata(wdata),
    .raddr(idx[AW-1:0]), .rdata(rdata)
  );

  function automatic logic [SW-1:0] mag_of(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  function automatic logic signed [32:0] sgn_of(input logic [SW-1:0] q,
                                                input logic neg);
    logic signed [32:0] t;
    t = 33'(q);
    return neg ? -t : t;
  endfunction

  // One restoring division step; divisor is count.
  function automatic logic [2*SW-1:0] div_step(input logic [SW-1:0] q,
                                               input logic [SW-1:0] r,
                                               input logic [CW-1:0] d);
    logic [SW:0] t;
    logic [SW-1:0] nq, nr;
    t = {r, q[SW-1]};
    nq = {q[SW-2:0], 1'b0};
    if (t >= (SW+1)'(d)) begin
      nr = SW'(t - (SW+1)'(d));
      nq[0] = 1'b1;
    end else begin
      nr = t[SW-1:0];
    end
    return {nq, nr};
  endfunction

  logic [35:0] trial;
  logic [35:0] remsh;
  assign remsh = {rem[33:0], rad[67:66]};
  assign trial = {root, 2'b01};

  logic [34:0] cand;
  assign cand = 35'(root) + 35'(rsph);

  // Select the axis to square; its product is registered in sq.
  always_comb begin
    case (axis)
      2'd0: mag = dx[33] ? 34'(-dx) : 34'(dx);
      2'd1: mag = dy[33] ? 34'(-dy) : 34'(dy);
      2'd2: mag = dz[33] ? 34'(-dz) : 34'(dz);
      default: mag = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsm_pkg::S_LOAD;
      count <= '0;
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        bsm_pkg::S_LOAD: begin
          if (store) begin
            count <= count + 1'b1;
            sum_x <= sum_x + SW'($signed(center_x));
            sum_y <= sum_y + SW'($signed(center_y));
            sum_z <= sum_z + SW'($signed(center_z));
          end
          if (accept && last_sphere) begin
            qx <= mag_of(sum_x + (store ? SW'($signed(center_x)) : '0));
            qy <= mag_of(sum_y + (store ? SW'($signed(center_y)) : '0));
            qz <= mag_of(sum_z + (store ? SW'($signed(center_z)) : '0));
            rx <= '0;
            ry <= '0;
            rz <= '0;
            dcnt <= '0;
            state <= bsm_pkg::S_DIV;
          end
        end
        bsm_pkg::S_DIV: begin
          if (count == '0) begin
            cx <= '0;
            cy <= '0;
            cz <= '0;
            idx <= '0;
            best <= '0;
            state <= bsm_pkg::S_OUT;
          end else if (dcnt == DCW'(SW)) begin
            cx <= sgn_of(qx, sum_x[SW-1]);
            cy <= sgn_of(qy, sum_y[SW-1]);
            cz <= sgn_of(qz, sum_z[SW-1]);
            idx <= '0;
            best <= '0;
            state <= bsm_pkg::S_RD;
          end else begin
            {qx, rx} <= div_step(qx, rx, count);
            {qy, ry} <= div_step(qy, ry, count);
            {qz, rz} <= div_step(qz, rz, count);
            dcnt <= dcnt + 1'b1;
          end
        end
        bsm_pkg::S_RD: state <= bsm_pkg::S_DIFF;
        bsm_pkg::S_DIFF: begin
          dx <= 34'($signed(rdata[126:95])) - 34'(cx);
          dy <= 34'($signed(rdata[94:63])) - 34'(cy);
          dz <= 34'($signed(rdata[62:31])) - 34'(cz);
          rsph <= rdata[30:0];
          axis <= 2'd0;
          sqsum <= '0;
          state <= bsm_pkg::S_SQ;
        end
        bsm_pkg::S_SQ: begin
          // Square one axis per cycle; accumulate the previous product.
          if (axis != 2'd0) sqsum <= sqsum + sq;
          axis <= axis + 1'b1;
          if (axis == 2'd3) begin
            rad <= sqsum + sq;
            rem <= '0;
            root <= '0;
            scnt <= '0;
            state <= bsm_pkg::S_SQRT;
          end
        end
        bsm_pkg::S_SQRT: begin
          rad <= {rad[65:0], 2'b00};
          if (remsh >= trial) begin
            rem <= remsh - trial;
            root <= {root[32:0], 1'b1};
          end else begin
            rem <= remsh;
            root <= {root[32:0], 1'b0};
          end
          scnt <= scnt + 1'b1;
          if (scnt == 6'd33) state <= bsm_pkg::S_CMP;
        end
        bsm_pkg::S_CMP: begin
          if (cand > best) best <= cand;
          if (idx + 1'b1 == count) begin
            state <= bsm_pkg::S_OUT;
          end else begin
            idx <= idx + 1'b1;
            state <= bsm_pkg::S_RD;
          end
        end
        bsm_pkg::S_OUT: begin
          done <= 1'b1;
          bound_x <= cx[31:0];
          bound_y <= cy[31:0];
          bound_z <= cz[31:0];
          if (best > 35'(bsm_pkg::RadMax)) begin
            bound_radius <= 31'(bsm_pkg::RadMax);
            radius_saturated <= 1'b1;
          end else begin
            bound_radius <= best[30:0];
            radius_saturated <= 1'b0;
          end
          count <= '0;
          sum_x <= '0;
          sum_y <= '0;
          sum_z <= '0;
          state <= bsm_pkg::S_LOAD;
        end
        default: state <= bsm_pkg::S_LOAD;
      endcase
    end
  end

  // Squarer output registered before accumulation.
  always_ff @(posedge clk) begin
    sq <= 68'(mag) * 68'(mag);
  end

`include "bounding_sphere_merge_assert.svh"
  `BSM_ASSERT_NEXT(a_done_once, done, !done, "result strobe lasted more than one cycle")
  `BSM_ASSERT_IMP(a_done_clears, done, count == '0, "set not cleared with result")
  `BSM_ASSERT_IMP(a_count_cap, 1'b1, count <= CW'(bsm_pkg::MaxSpheres), "count over capacity")
  `BSM_ASSERT_IMP(a_sat_flag, done && radius_saturated,
                  bound_radius == 31'(bsm_pkg::RadMax), "saturation without clamp")
endmodule

>>> hdl/bsm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module bsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> test/bsm_checker.sv
// Checker for the bounding sphere merge block: predicts each enclosing sphere and compares.
`timescale 1ns / 100ps
module bsm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] center_x,
  input  logic [31:0] center_y,
  input  logic [31:0] center_z,
  input  logic [30:0] sphere_radius,
  input  logic        last_sphere,
  input  logic        done,
  input  logic [31:0] bound_x,
  input  logic [31:0] bound_y,
  input  logic [31:0] bound_z,
  input  logic [30:0] bound_radius,
  input  logic        radius_saturated,
  output int          fail_count,
  output int          pending,
  output int          bound_count
);
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [30:0] r;
    logic        sat;
  } bound_t;

  logic signed [31:0] held_x [bsm_pkg::MaxSpheres];
  logic signed [31:0] held_y [bsm_pkg::MaxSpheres];
  logic signed [31:0] held_z [bsm_pkg::MaxSpheres];
  logic [30:0]        held_r [bsm_pkg::MaxSpheres];
  logic signed [63:0] acc_x, acc_y, acc_z;
  int                 held_n;
  bound_t             bound_queue [$];

  function automatic logic [67:0] floor_sqrt(input logic [67:0] v);
    logic [67:0] rem, root, trial;
    rem = 0;
    root = 0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 68'd3);
      trial = (root << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 68'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic bound_t enclose_set();
    bound_t b;
    logic signed [63:0] cx, cy, cz;
    logic signed [67:0] dx, dy, dz;
    logic [67:0] reach, best;
    cx = 0; cy = 0; cz = 0;
    best = 0;
    if (held_n != 0) begin
      cx = acc_x / held_n;
      cy = acc_y / held_n;
      cz = acc_z / held_n;
    end
    for (int i = 0; i < held_n; i++) begin
      dx = 68'(held_x[i]) - 68'(cx);
      dy = 68'(held_y[i]) - 68'(cy);
      dz = 68'(held_z[i]) - 68'(cz);
      reach = floor_sqrt(68'(dx * dx) + 68'(dy * dy) + 68'(dz * dz)) + 68'(held_r[i]);
      if (reach > best) best = reach;
    end
    b.sat = best > 68'h7FFF_FFFF;
    b.r = b.sat ? 31'h7FFF_FFFF : best[30:0];
    b.x = cx[31:0];
    b.y = cy[31:0];
    b.z = cz[31:0];
    return b;
  endfunction

  assign pending = bound_queue.size();

  always @(posedge clk) begin
    bound_t got, want;
    if (rst) begin
      held_n = 0;
      acc_x = 0; acc_y = 0; acc_z = 0;
      fail_count <= 0;
      bound_count <= 0;
      bound_queue.delete();
    end else begin
      if (done) begin
        got = '{bound_x, bound_y, bound_z, bound_radius, radius_saturated};
        bound_count <= bound_count + 1;
        if (bound_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = bound_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch x exp %h act %h, y exp %h act %h, z exp %h act %h",
                     $time, want.x, got.x, want.y, got.y, want.z, got.z);
            $display("%0t:   radius exp %h act %h, saturated exp %b act %b",
                     $time, want.r, got.r, want.sat, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        // store and sum in place, then close the set on the last mark
        if (held_n < bsm_pkg::MaxSpheres) begin
          held_x[held_n] = center_x;
          held_y[held_n] = center_y;
          held_z[held_n] = center_z;
          held_r[held_n] = sphere_radius;
          acc_x = acc_x + 64'(signed'(center_x));
          acc_y = acc_y + 64'(signed'(center_y));
          acc_z = acc_z + 64'(signed'(center_z));
          held_n = held_n + 1;
        end
        if (last_sphere) begin
          bound_queue.insert(bound_queue.size(), enclose_set());
          held_n = 0;
          acc_x = 0; acc_y = 0; acc_z = 0;
        end
      end
    end
  end
endmodule

>>> test/tb_bounding_sphere_merge.sv
// Testbench top for the bounding sphere merge block: stimulus and verdict.
`timescale 1ns / 100ps
module tb_bounding_sphere_merge;
  logic        clk = 0, rst = 1, start = 0, last_sphere = 0;
  logic [31:0] center_x = 0, center_y = 0, center_z = 0;
  logic [30:0] sphere_radius = 0;
  logic        busy, done, radius_saturated;
  logic [31:0] bound_x, bound_y, bound_z;
  logic [30:0] bound_radius;
  int          fail_count, pending, bound_count;
  int          idle_pct, sent;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  bounding_sphere_merge dut (.*);
  bsm_checker checker_i (.*);

  // one request: hold until accepted, with an optional idle cycle first
  task automatic send_sphere(input logic [31:0] x, y, z, input logic [30:0] r,
                             input logic last);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    center_x <= x; center_y <= y; center_z <= z;
    sphere_radius <= r; last_sphere <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  function automatic logic [31:0] pick_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return 32'h7FFF_FFFF - $urandom_range(3);
      default: return 32'($signed($urandom_range(2000)) - 1000) << $urandom_range(16);
    endcase
  endfunction

  task automatic random_set(input int n);
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < n; i++)
      send_sphere(pick_coord(mode), pick_coord(mode), pick_coord(mode),
                  ($urandom_range(7) == 0) ? 31'h7FFF_FFFF : 31'($urandom()) >> $urandom_range(30),
                  i == n - 1);
  endtask

  initial begin
    #20_000_000;
    $display("** bounding_sphere_merge: FAILED **");
    $finish;
  end

  initial begin
    idle_pct = 12;
    sent = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    // directed: single spheres at extremes, opposite corners, saturation
    send_sphere(0, 0, 0, 0, 1);
    send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1);
    send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1);
    send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 5, 0);
    send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 7, 1);
    send_sphere(-3, 0, 0, 1, 0);
    send_sphere(0, 0, 0, 1, 1);
    // store full: 64 held, extra spheres dropped, last mark on a dropped one
    for (int i = 0; i < 66; i++)
      send_sphere(32'(i) << 16, -(32'(i) << 12), 32'(i * 7), 31'(i), i == 65);
    random_set(64);
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 12 : (phase == 1) ? 73 : 0;
      while (sent < 220 + phase * 765)
        random_set(($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8));
    end
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d spheres in sets of 1 to 70, checked %0d enclosing spheres.",
             sent, bound_count);
    if (fail_count == 0)
      $display("** bounding_sphere_merge: PASSED **");
    else
      $display("** bounding_sphere_merge: FAILED **");
    $finish;
  end
endmodule
